// ===== rtl/hdt_pkg.sv =====
package hdt_pkg;

   localparam int NODE_DEPTH  = 1024;
   localparam int ENTRY_DEPTH = 1024;
   localparam int KEY_BITS    = 32;
   localparam int VALUE_BITS  = 32;
   localparam int HASH_BITS   = 64;

   localparam int DIGIT_BITS = 2;
   localparam int DIGIT_WAYS = 1 << DIGIT_BITS;
   localparam int DIGIT_MAX  = HASH_BITS / DIGIT_BITS;
   localparam int DIGIT_CW   = $clog2(DIGIT_MAX + 1);

   localparam int NODE_AW  = $clog2(NODE_DEPTH);
   localparam int NODE_CW  = $clog2(NODE_DEPTH + 1);
   localparam int ENTRY_AW = $clog2(ENTRY_DEPTH);
   localparam int ENTRY_CW = $clog2(ENTRY_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_NODE,
      S_CHAIN,
      S_APPEND,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               ok;
      logic [NODE_AW-1:0] idx;
   } node_link_type;

   typedef struct packed {
      logic                ok;
      logic [ENTRY_AW-1:0] idx;
   } entry_link_type;

   typedef struct packed {
      entry_link_type                 head;
      node_link_type [DIGIT_WAYS-1:0] child;
   } node_type;

   typedef struct packed {
      entry_link_type        next;
      logic [VALUE_BITS-1:0] value;
      logic [KEY_BITS-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic               we;
      logic [NODE_AW-1:0] waddr;
      node_type           wdata;
      logic [NODE_AW-1:0] raddr;
   } node_port_type;

   typedef struct packed {
      logic                we;
      logic [ENTRY_AW-1:0] waddr;
      entry_type           wdata;
      logic [ENTRY_AW-1:0] raddr;
   } entry_port_type;

   function automatic logic [DIGIT_CW-1:0] digit_count(input logic [HASH_BITS-1:0] h);
      logic [DIGIT_CW-1:0] n;
      n = '0;
      for (int i = 0; i < DIGIT_MAX; i++) begin
         if (h[DIGIT_BITS*i +: DIGIT_BITS] != '0) begin
            n = DIGIT_CW'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/hdt_ram.sv =====
module hdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/hdt_ctrl.sv =====
module hdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [0:0]             req_kind,
   input  logic [63:0]            req_hash_value,
   input  logic [31:0]            req_lookup_key,
   input  logic [31:0]            req_store_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [31:0]            rsp_read_value,
   output hdt_pkg::node_port_type  node_port,
   input  hdt_pkg::node_type       node_rdata,
   output hdt_pkg::entry_port_type entry_port,
   input  hdt_pkg::entry_type      entry_rdata
);

   hdt_pkg::state_type                 state_ff, state_in;
   hdt_pkg::op_type                    kind_ff, kind_in;
   logic [hdt_pkg::HASH_BITS-1:0]      rem_ff, rem_in;
   logic [hdt_pkg::KEY_BITS-1:0]       key_ff, key_in;
   logic [hdt_pkg::VALUE_BITS-1:0]     val_ff, val_in;
   logic [hdt_pkg::NODE_AW-1:0]        cur_ff, cur_in;
   logic                               fresh_ff, fresh_in;
   logic                               root_clean_ff, root_clean_in;
   logic [hdt_pkg::NODE_CW-1:0]        node_count_ff, node_count_in;
   logic [hdt_pkg::ENTRY_CW-1:0]       entry_count_ff, entry_count_in;
   logic [hdt_pkg::ENTRY_AW-1:0]       eidx_ff, eidx_in;
   hdt_pkg::status_type                res_status_ff, res_status_in;
   logic [hdt_pkg::VALUE_BITS-1:0]     res_value_ff, res_value_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   hdt_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [31:0]                        rsp_value_ff, rsp_value_in;

   hdt_pkg::node_type                  node_cur;
   hdt_pkg::node_type                  node_mod;
   hdt_pkg::entry_type                 entry_mod;
   logic [hdt_pkg::DIGIT_BITS-1:0]     digit;
   logic [hdt_pkg::DIGIT_CW-1:0]       ndigits;
   logic [hdt_pkg::NODE_CW:0]          node_need;
   logic                               full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= hdt_pkg::S_IDLE;
         root_clean_ff  <= 1'b0;
         node_count_ff  <= hdt_pkg::NODE_CW'(1);
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         root_clean_ff  <= root_clean_in;
         node_count_ff  <= node_count_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      rem_ff        <= rem_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      fresh_ff      <= fresh_in;
      eidx_ff       <= eidx_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // fresh nodes and the untouched root read as empty
   always_comb begin
      if (fresh_ff || (cur_ff == '0 && !root_clean_ff)) begin
         node_cur = '0;
      end else begin
         node_cur = node_rdata;
      end
   end

   assign digit     = rem_ff[hdt_pkg::DIGIT_BITS-1:0];
   assign ndigits   = hdt_pkg::digit_count(rem_ff);
   assign node_need = (hdt_pkg::NODE_CW+1)'(node_count_ff)
                      + (hdt_pkg::NODE_CW+1)'(ndigits);
   assign full      = (node_need > (hdt_pkg::NODE_CW+1)'(hdt_pkg::NODE_DEPTH))
                      || (entry_count_ff >= hdt_pkg::ENTRY_CW'(hdt_pkg::ENTRY_DEPTH));

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      rem_in         = rem_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      cur_in         = cur_ff;
      fresh_in       = fresh_ff;
      root_clean_in  = root_clean_ff;
      node_count_in  = node_count_ff;
      entry_count_in = entry_count_ff;
      eidx_in        = eidx_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      node_mod       = node_cur;
      entry_mod      = entry_rdata;
      node_port      = '0;
      entry_port     = '0;

      case (state_ff)
         hdt_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in  = hdt_pkg::op_type'(req_kind);
               rem_in   = req_hash_value[hdt_pkg::HASH_BITS-1:0];
               key_in   = req_lookup_key[hdt_pkg::KEY_BITS-1:0];
               val_in   = req_store_value[hdt_pkg::VALUE_BITS-1:0];
               cur_in   = '0;
               fresh_in = 1'b0;
               state_in = hdt_pkg::S_CHECK;
            end
         end
         hdt_pkg::S_CHECK: begin
            if (kind_ff == hdt_pkg::OP_INSERT && full) begin
               res_status_in = hdt_pkg::ST_FULL;
               res_value_in  = '0;
               state_in      = hdt_pkg::S_DONE;
            end else begin
               state_in = hdt_pkg::S_NODE;
            end
         end
         hdt_pkg::S_NODE: begin
            if (rem_ff != '0) begin
               rem_in = rem_ff >> hdt_pkg::DIGIT_BITS;
               if (node_cur.child[digit].ok) begin
                  cur_in = node_cur.child[digit].idx;
               end else if (kind_ff == hdt_pkg::OP_LOOKUP) begin
                  res_status_in = hdt_pkg::ST_NOT_FOUND;
                  res_value_in  = '0;
                  state_in      = hdt_pkg::S_DONE;
               end else begin
                  node_mod.child[digit].ok  = 1'b1;
                  node_mod.child[digit].idx = node_count_ff[hdt_pkg::NODE_AW-1:0];
                  node_port.we    = 1'b1;
                  node_port.waddr = cur_ff;
                  node_port.wdata = node_mod;
                  if (cur_ff == '0) begin
                     root_clean_in = 1'b1;
                  end
                  cur_in        = node_count_ff[hdt_pkg::NODE_AW-1:0];
                  fresh_in      = 1'b1;
                  node_count_in = node_count_ff + hdt_pkg::NODE_CW'(1);
               end
            end else if (node_cur.head.ok) begin
               eidx_in  = node_cur.head.idx;
               state_in = hdt_pkg::S_CHAIN;
            end else if (kind_ff == hdt_pkg::OP_LOOKUP) begin
               res_status_in = hdt_pkg::ST_NOT_FOUND;
               res_value_in  = '0;
               state_in      = hdt_pkg::S_DONE;
            end else begin
               node_mod.head.ok  = 1'b1;
               node_mod.head.idx = entry_count_ff[hdt_pkg::ENTRY_AW-1:0];
               node_port.we      = 1'b1;
               node_port.waddr   = cur_ff;
               node_port.wdata   = node_mod;
               if (cur_ff == '0) begin
                  root_clean_in = 1'b1;
               end
               entry_port.we          = 1'b1;
               entry_port.waddr       = entry_count_ff[hdt_pkg::ENTRY_AW-1:0];
               entry_port.wdata.key   = key_ff;
               entry_port.wdata.value = val_ff;
               entry_port.wdata.next  = '0;
               entry_count_in = entry_count_ff + hdt_pkg::ENTRY_CW'(1);
               res_status_in  = hdt_pkg::ST_NEW;
               res_value_in   = '0;
               state_in       = hdt_pkg::S_DONE;
            end
         end
         hdt_pkg::S_CHAIN: begin
            if (entry_rdata.key == key_ff) begin
               if (kind_ff == hdt_pkg::OP_LOOKUP) begin
                  res_status_in = hdt_pkg::ST_FOUND;
                  res_value_in  = entry_rdata.value;
               end else begin
                  entry_mod.value  = val_ff;
                  entry_port.we    = 1'b1;
                  entry_port.waddr = eidx_ff;
                  entry_port.wdata = entry_mod;
                  res_status_in    = hdt_pkg::ST_UPDATED;
                  res_value_in     = '0;
               end
               state_in = hdt_pkg::S_DONE;
            end else if (!entry_rdata.next.ok) begin
               if (kind_ff == hdt_pkg::OP_LOOKUP) begin
                  res_status_in = hdt_pkg::ST_NOT_FOUND;
                  res_value_in  = '0;
                  state_in      = hdt_pkg::S_DONE;
               end else begin
                  entry_mod.next.ok  = 1'b1;
                  entry_mod.next.idx = entry_count_ff[hdt_pkg::ENTRY_AW-1:0];
                  entry_port.we      = 1'b1;
                  entry_port.waddr   = eidx_ff;
                  entry_port.wdata   = entry_mod;
                  state_in           = hdt_pkg::S_APPEND;
               end
            end else begin
               eidx_in = entry_rdata.next.idx;
            end
         end
         hdt_pkg::S_APPEND: begin
            entry_port.we          = 1'b1;
            entry_port.waddr       = entry_count_ff[hdt_pkg::ENTRY_AW-1:0];
            entry_port.wdata.key   = key_ff;
            entry_port.wdata.value = val_ff;
            entry_port.wdata.next  = '0;
            entry_count_in = entry_count_ff + hdt_pkg::ENTRY_CW'(1);
            res_status_in  = hdt_pkg::ST_NEW;
            res_value_in   = '0;
            state_in       = hdt_pkg::S_DONE;
         end
         hdt_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = 32'(res_value_ff);
               state_in      = hdt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = hdt_pkg::S_IDLE;
         end
      endcase

      node_port.raddr  = cur_in;
      entry_port.raddr = eidx_in;
   end

   assign req_ready      = (state_ff == hdt_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ===== rtl/hash_digit_trie_table.sv =====
// Key/value map on a 4-ary trie of 2-bit hash digits with per-leaf key chains.
// Input channel req_*: one item carries kind (insert/update or lookup), a
// precomputed hash, a key and a value; it is accepted when req_valid and
// req_ready are both high. Result channel rsp_*: one item per input item with
// status (new, updated, found, not found, full) and the value read on a hit.
// After acceptance an item passes a check step, trie steps for the links
// followed or allocated (up to 32), chain steps for the entries visited, an
// append step for an insert that adds to a chain, and a done step that loads
// the result; an insert refused as full goes from the check to the done step.
// Each trie step and each chain step costs one read of the node or entry
// memory. The block works on one item at a time and is ready again the cycle
// after its result is loaded.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and works the next item and holds its result until
// the output register is free.
// Reset empties the map at once: counters return to one node and no entries
// and the root reads as empty through a flag, so there is no clearing pass.
module hash_digit_trie_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_kind,
   input  logic [63:0] req_hash_value,
   input  logic [31:0] req_lookup_key,
   input  logic [31:0] req_store_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_read_value
);

   hdt_pkg::node_port_type  node_port;
   hdt_pkg::node_type       node_rdata;
   hdt_pkg::entry_port_type entry_port;
   hdt_pkg::entry_type      entry_rdata;

   hdt_ram #(
      .WIDTH($bits(hdt_pkg::node_type)),
      .DEPTH(hdt_pkg::NODE_DEPTH)
   ) u_node_ram (
      .clock(clock),
      .we   (node_port.we),
      .waddr(node_port.waddr),
      .wdata(node_port.wdata),
      .raddr(node_port.raddr),
      .rdata(node_rdata)
   );

   hdt_ram #(
      .WIDTH($bits(hdt_pkg::entry_type)),
      .DEPTH(hdt_pkg::ENTRY_DEPTH)
   ) u_entry_ram (
      .clock(clock),
      .we   (entry_port.we),
      .waddr(entry_port.waddr),
      .wdata(entry_port.wdata),
      .raddr(entry_port.raddr),
      .rdata(entry_rdata)
   );

   hdt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_hash_value (req_hash_value),
      .req_lookup_key (req_lookup_key),
      .req_store_value(req_store_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .node_port      (node_port),
      .node_rdata     (node_rdata),
      .entry_port     (entry_port),
      .entry_rdata    (entry_rdata)
   );

`ifndef ASSERT_OFF
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !node_port.we && !entry_port.we)
      else $error("memory written while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !node_port.we && !entry_port.we)
      else $error("item accepted without leaving idle");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");
`endif

endmodule
